/* rtl/hb64_pkg.sv */
// hb64_pkg: shared types, character constants and code conversion functions for the hex to base64 encoder
package hb64_pkg;

	// ascii characters used for decode and encode
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;

	// base64 alphabet boundaries
	localparam logic [5:0] B64_LOWER_BASE = 6'd26;
	localparam logic [5:0] B64_DIGIT_BASE = 6'd52;
	localparam logic [5:0] B64_PLUS_CODE  = 6'd62;

	// hex letters start at ten
	localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

	// pending bit counts
	localparam logic [2:0] CNT_EMPTY = 3'd0;
	localparam logic [2:0] CNT_TWO   = 3'd2;
	localparam logic [2:0] CNT_FOUR  = 3'd4;

	typedef struct packed {
		logic [7:0] hex_char;
		logic       end_of_text;
	} hex_item_t;

	typedef struct packed {
		logic [7:0] base64_char;
		logic       last_char;
		logic       bad_digit;
	} b64_item_t;

	// result of one digit against the pending buffer
	typedef struct packed {
		logic [1:0] num_res;
		logic [7:0] char0;
		logic [7:0] char1;
		logic       last0;
		logic       last1;
		logic       bad;
		logic [3:0] nxt_bits;
		logic [2:0] nxt_cnt;
	} hb64_step_t;

	function automatic logic [4:0] hex_decode(input logic [7:0] ch);
		logic [4:0] res;
		res = {1'b1, 4'd0};
		if (ch >= CH_ZERO && ch <= CH_NINE)
			res = {1'b0, 4'(ch - CH_ZERO)};
		else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F)
			res = {1'b0, 4'(ch - CH_UPPER_A) + HEX_LETTER_BASE};
		return res;
	endfunction

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] res;
		if (v < B64_LOWER_BASE)
			res = CH_UPPER_A + {2'b00, v};
		else if (v < B64_DIGIT_BASE)
			res = CH_LOWER_A + {2'b00, v - B64_LOWER_BASE};
		else if (v < B64_PLUS_CODE)
			res = CH_ZERO + {2'b00, v - B64_DIGIT_BASE};
		else if (v == B64_PLUS_CODE)
			res = CH_PLUS;
		else
			res = CH_SLASH;
		return res;
	endfunction

endpackage

/* rtl/hex_to_base64_encoder_top.sv */
// hex_to_base64_encoder_top: streaming hex digit to base64 character converter
// an input transfer is held in the input register, and its characters then in the output pair register
// throughput: one digit per cycle while the output accepts; an end-of-text digit with four bits pending gives two
// characters, which leave one after the other through the output pair register
// reset clears the pending bit buffer and the valid flags of the input register and the output pair register
// digits that produce no character pass through the input register without using the output
module hex_to_base64_encoder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                hex_valid,
	output logic                hex_ready,
	input  hb64_pkg::hex_item_t hex_data,
	output logic                b64_valid,
	input  logic                b64_ready,
	output hb64_pkg::b64_item_t b64_data
);

	logic                valid_s1;
	hb64_pkg::hex_item_t item_s1;
	logic [3:0]          pend_bits_q;
	logic [2:0]          pend_cnt_q;

	logic                valid_s2;
	logic                two_s2;
	logic                sel_s2;
	logic [7:0]          char0_s2;
	logic [7:0]          char1_s2;
	logic                last0_s2;
	logic                last1_s2;
	logic                bad_s2;

	hb64_pkg::hb64_step_t step;
	logic                 s2_done;
	logic                 s2_free;
	logic                 adv_s1;

	hb64_core u_core (
		.item      (item_s1),
		.pend_bits (pend_bits_q),
		.pend_cnt  (pend_cnt_q),
		.step      (step)
	);

	// pair register empties after the transfer of its final character
	assign s2_done   = valid_s2 && b64_ready && (sel_s2 || !two_s2);
	assign s2_free   = !valid_s2 || s2_done;
	assign adv_s1    = valid_s1 && (step.num_res == 2'd0 || s2_free);
	assign hex_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pend_bits_q <= '0;
			pend_cnt_q  <= hb64_pkg::CNT_EMPTY;
		end else begin
			if (hex_ready)
				valid_s1 <= hex_valid;
			if (adv_s1) begin
				pend_bits_q <= step.nxt_bits;
				pend_cnt_q  <= step.nxt_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hex_ready && hex_valid)
			item_s1 <= hex_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			two_s2   <= 1'b0;
			sel_s2   <= 1'b0;
		end else begin
			if (adv_s1 && step.num_res != 2'd0) begin
				valid_s2 <= 1'b1;
				two_s2   <= step.num_res == 2'd2;
				sel_s2   <= 1'b0;
			end else if (s2_done) begin
				valid_s2 <= 1'b0;
				sel_s2   <= 1'b0;
			end else if (valid_s2 && b64_ready) begin
				// first of two characters went out
				sel_s2 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && step.num_res != 2'd0) begin
			char0_s2 <= step.char0;
			char1_s2 <= step.char1;
			last0_s2 <= step.last0;
			last1_s2 <= step.last1;
			bad_s2   <= step.bad;
		end
	end

	assign b64_valid            = valid_s2;
	assign b64_data.base64_char = sel_s2 ? char1_s2 : char0_s2;
	assign b64_data.last_char   = sel_s2 ? last1_s2 : last0_s2;
	assign b64_data.bad_digit   = bad_s2;

endmodule

/* rtl/hb64_core.sv */
// hb64_core: merges one hex digit into the pending bits and forms up to two base64 characters
module hb64_core (
	input  hb64_pkg::hex_item_t  item,
	input  logic [3:0]           pend_bits,
	input  logic [2:0]           pend_cnt,
	output hb64_pkg::hb64_step_t step
);

	logic [4:0] dec;
	logic [3:0] digit;
	logic [5:0] grp0;
	logic [5:0] grp1;

	assign dec   = hb64_pkg::hex_decode(item.hex_char);
	assign digit = dec[3:0];

	always_comb begin
		grp0          = '0;
		grp1          = '0;
		step.num_res  = 2'd0;
		step.last0    = 1'b0;
		step.last1    = 1'b0;
		step.bad      = dec[4];
		step.nxt_bits = '0;
		step.nxt_cnt  = hb64_pkg::CNT_EMPTY;
		unique case (pend_cnt)
			hb64_pkg::CNT_EMPTY: begin
				if (item.end_of_text) begin
					// lone digit padded with zeros on the right
					grp0         = {digit, 2'b00};
					step.num_res = 2'd1;
					step.last0   = 1'b1;
				end else begin
					step.nxt_bits = digit;
					step.nxt_cnt  = hb64_pkg::CNT_FOUR;
				end
			end
			hb64_pkg::CNT_TWO: begin
				grp0         = {pend_bits[1:0], digit};
				step.num_res = 2'd1;
				step.last0   = item.end_of_text;
			end
			default: begin
				// four pending bits; any count other than zero or two behaves the same
				grp0 = {pend_bits, digit[3:2]};
				if (item.end_of_text) begin
					grp1         = {digit[1:0], 4'b0000};
					step.num_res = 2'd2;
					step.last1   = 1'b1;
				end else begin
					step.num_res  = 2'd1;
					step.nxt_bits = {2'b00, digit[1:0]};
					step.nxt_cnt  = hb64_pkg::CNT_TWO;
				end
			end
		endcase
		step.char0 = hb64_pkg::b64_char(grp0);
		step.char1 = hb64_pkg::b64_char(grp1);
	end

endmodule
